@@ hdl/solar_buffer_charge_controller_macros.svh @@
// ---------------------------------------------------------------------------
// Solar buffer charge controller assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SOLAR_BUFFER_CHARGE_CONTROLLER_MACROS_SVH
`define SOLAR_BUFFER_CHARGE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBCC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sbcc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sbcc assertion failed");

`endif

@@ hdl/sbcc_pkg.sv @@
// ---------------------------------------------------------------------------
// Solar buffer charge controller package
// Widths, register indexes, mode codes and the structs shared by the block.
// ---------------------------------------------------------------------------
package sbcc_pkg;

	localparam int TEMP_W     = 13;
	localparam int DIFF_W     = 10;
	localparam int RUNON_W    = 8;
	localparam int HOURS_W    = 16;
	localparam int MIN_W      = 6;
	localparam int PRESC_W    = 3;
	localparam int MODE_W     = 2;
	localparam int IDX_W      = 3;
	localparam int CFG_DATA_W = 13;
	localparam int CALC_W     = 16;

	localparam int TICKS_PER_MINUTE = 6;
	localparam int MINUTES_PER_HOUR = 60;
	localparam int LIMIT_MARGIN     = 20;

	localparam logic [IDX_W-1:0] REG_OPERATING_MODE       = 3'd0;
	localparam logic [IDX_W-1:0] REG_PUMP_STATIC          = 3'd1;
	localparam logic [IDX_W-1:0] REG_COLLECTOR_START_TEMP = 3'd2;
	localparam logic [IDX_W-1:0] REG_COLLECTOR_END_TEMP   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DIFF_START           = 3'd4;
	localparam logic [IDX_W-1:0] REG_DIFF_END             = 3'd5;
	localparam logic [IDX_W-1:0] REG_BUFFER_MAX_TEMP      = 3'd6;
	localparam logic [IDX_W-1:0] REG_RUN_ON_MINUTES       = 3'd7;

	localparam logic [MODE_W-1:0] MODE_AUTO       = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MANUAL_OFF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL_ON  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]        operating_mode;
		logic                     pump_static;
		logic signed [TEMP_W-1:0] collector_start_temp;
		logic signed [TEMP_W-1:0] collector_end_temp;
		logic [DIFF_W-1:0]        diff_start;
		logic [DIFF_W-1:0]        diff_end;
		logic signed [TEMP_W-1:0] buffer_max_temp;
		logic [RUNON_W-1:0]       run_on_minutes;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		operating_mode:       MODE_AUTO,
		pump_static:          1'b1,
		collector_start_temp: 13'sd400,
		collector_end_temp:   13'sd300,
		diff_start:           10'd80,
		diff_end:             10'd30,
		buffer_max_temp:      13'sd900,
		run_on_minutes:       8'd2
	};

	typedef struct packed {
		logic signed [TEMP_W-1:0] upper_temp;
		logic                     upper_ok;
		logic signed [TEMP_W-1:0] lower_temp;
		logic                     lower_ok;
		logic signed [TEMP_W-1:0] collector_temp;
		logic                     collector_ok;
		logic                     alarm_present;
		logic                     alarm_active;
	} item_t;

	typedef struct packed {
		logic                pump_on;
		logic                charging;
		logic [RUNON_W-1:0]  run_on_left;
		logic [HOURS_W-1:0]  runtime_hours;
		logic                hours_updated;
	} result_t;

	typedef struct packed {
		logic                charge_flag;
		logic                pump_relay;
		logic [RUNON_W-1:0]  run_on_count;
		logic [PRESC_W-1:0]  runtime_prescale;
		logic [PRESC_W-1:0]  off_prescale;
		logic [MIN_W-1:0]    runtime_minutes_count;
		logic [HOURS_W-1:0]  runtime_hours_count;
	} state_t;

endpackage

@@ hdl/sbcc_item_if.sv @@
// ---------------------------------------------------------------------------
// Sensor item channel
// Valid/ready channel carrying one tick's sensor readings.
// ---------------------------------------------------------------------------
interface sbcc_item_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sbcc_pkg::TEMP_W-1:0]   upper_temp;
	logic                                 upper_ok;
	logic signed [sbcc_pkg::TEMP_W-1:0]   lower_temp;
	logic                                 lower_ok;
	logic signed [sbcc_pkg::TEMP_W-1:0]   collector_temp;
	logic                                 collector_ok;
	logic                                 alarm_present;
	logic                                 alarm_active;

	modport source (
		output valid, upper_temp, upper_ok, lower_temp, lower_ok,
		       collector_temp, collector_ok, alarm_present, alarm_active,
		input  ready
	);
	modport sink (
		input  valid, upper_temp, upper_ok, lower_temp, lower_ok,
		       collector_temp, collector_ok, alarm_present, alarm_active,
		output ready
	);
endinterface

@@ hdl/sbcc_result_if.sv @@
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the pump and runtime status of one tick.
// ---------------------------------------------------------------------------
interface sbcc_result_if;
	logic                             valid;
	logic                             ready;
	logic                             pump_on;
	logic                             charging;
	logic [sbcc_pkg::RUNON_W-1:0]     run_on_left;
	logic [sbcc_pkg::HOURS_W-1:0]     runtime_hours;
	logic                             hours_updated;

	modport source (
		output valid, pump_on, charging, run_on_left, runtime_hours, hours_updated,
		input  ready
	);
	modport sink (
		input  valid, pump_on, charging, run_on_left, runtime_hours, hours_updated,
		output ready
	);
endinterface

@@ hdl/sbcc_cfg_if.sv @@
// ---------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ---------------------------------------------------------------------------
interface sbcc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sbcc_pkg::IDX_W-1:0]         reg_index;
	logic [sbcc_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, reg_index, data, input ready);
	modport sink (input valid, reg_index, data, output ready);
endinterface

@@ hdl/sbcc_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the operating mode, thresholds and run-on time written over the
// configuration channel.
// ---------------------------------------------------------------------------
module sbcc_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	sbcc_cfg_if.sink         cfg,
	output sbcc_pkg::cfg_t   regs
);

	sbcc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= sbcc_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				sbcc_pkg::REG_OPERATING_MODE: begin
					regs_q.operating_mode <= cfg.data[sbcc_pkg::MODE_W-1:0];
				end
				sbcc_pkg::REG_PUMP_STATIC: begin
					regs_q.pump_static <= cfg.data[0];
				end
				sbcc_pkg::REG_COLLECTOR_START_TEMP: begin
					regs_q.collector_start_temp <= signed'(cfg.data[sbcc_pkg::TEMP_W-1:0]);
				end
				sbcc_pkg::REG_COLLECTOR_END_TEMP: begin
					regs_q.collector_end_temp <= signed'(cfg.data[sbcc_pkg::TEMP_W-1:0]);
				end
				sbcc_pkg::REG_DIFF_START: begin
					regs_q.diff_start <= cfg.data[sbcc_pkg::DIFF_W-1:0];
				end
				sbcc_pkg::REG_DIFF_END: begin
					regs_q.diff_end <= cfg.data[sbcc_pkg::DIFF_W-1:0];
				end
				sbcc_pkg::REG_BUFFER_MAX_TEMP: begin
					regs_q.buffer_max_temp <= signed'(cfg.data[sbcc_pkg::TEMP_W-1:0]);
				end
				sbcc_pkg::REG_RUN_ON_MINUTES: begin
					regs_q.run_on_minutes <= cfg.data[sbcc_pkg::RUNON_W-1:0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

endmodule

@@ hdl/sbcc_tick_logic.sv @@
// ---------------------------------------------------------------------------
// Tick logic
// Works out the next controller state and the result of one tick from the
// current state, the configuration and the sensor readings.
// ---------------------------------------------------------------------------
module sbcc_tick_logic (
	input  sbcc_pkg::cfg_t     cfg,
	input  sbcc_pkg::state_t   st,
	input  sbcc_pkg::item_t    it,
	output sbcc_pkg::state_t   st_next,
	output sbcc_pkg::result_t  res
);

	localparam int CW = sbcc_pkg::CALC_W;

	logic signed [CW-1:0] upper_s;
	logic signed [CW-1:0] lower_s;
	logic signed [CW-1:0] coll_s;
	logic signed [CW-1:0] limit_s;
	logic signed [CW-1:0] margin_s;
	logic signed [CW-1:0] start_t_s;
	logic signed [CW-1:0] end_t_s;
	logic signed [CW-1:0] dstart_s;
	logic signed [CW-1:0] dend_s;
	logic signed [CW-1:0] tmax;
	logic signed [CW-1:0] tmin;
	logic signed [CW-1:0] cdiff;
	logic                 alarm;
	logic                 manual;
	logic                 start_ok;
	logic                 stop_ok;
	logic [sbcc_pkg::PRESC_W:0] rp_inc;
	logic [sbcc_pkg::PRESC_W:0] op_inc;
	logic [sbcc_pkg::MIN_W-1:0] min_inc;
	logic [sbcc_pkg::RUNON_W-1:0] ron;
	logic                 hours_upd;

	always_comb begin
		upper_s   = CW'(it.upper_temp);
		lower_s   = CW'(it.lower_temp);
		coll_s    = CW'(it.collector_temp);
		limit_s   = CW'(cfg.buffer_max_temp);
		margin_s  = limit_s - CW'(sbcc_pkg::LIMIT_MARGIN);
		start_t_s = CW'(cfg.collector_start_temp);
		end_t_s   = CW'(cfg.collector_end_temp);
		dstart_s  = signed'({{(CW-sbcc_pkg::DIFF_W){1'b0}}, cfg.diff_start});
		dend_s    = signed'({{(CW-sbcc_pkg::DIFF_W){1'b0}}, cfg.diff_end});
		alarm     = it.alarm_present & it.alarm_active;
		manual    = (cfg.operating_mode == sbcc_pkg::MODE_MANUAL_OFF) ||
		            (cfg.operating_mode == sbcc_pkg::MODE_MANUAL_ON);

		// pick buffer max and min from the healthy sensors, or one above the limit if none
		if (it.upper_ok && it.lower_ok) begin
			if (upper_s > lower_s) begin
				tmax = upper_s;
				tmin = lower_s;
			end else begin
				tmax = lower_s;
				tmin = upper_s;
			end
		end else if (it.upper_ok) begin
			tmax = upper_s;
			tmin = upper_s;
		end else if (it.lower_ok) begin
			tmax = lower_s;
			tmin = lower_s;
		end else begin
			tmax = limit_s + CW'(1);
			tmin = limit_s + CW'(1);
		end
		cdiff = coll_s - tmin;

		start_ok = !st.charge_flag && it.collector_ok && (coll_s > start_t_s) &&
		           (cdiff > dstart_s) && (tmax < margin_s) && !alarm;
		// stopping ignores collector health
		stop_ok  = st.charge_flag && ((tmax >= limit_s) || (coll_s < end_t_s) ||
		           (cdiff < dend_s) || alarm);

		st_next   = st;
		hours_upd = 1'b0;
		rp_inc    = {1'b0, st.runtime_prescale} + 1'b1;
		op_inc    = {1'b0, st.off_prescale} + 1'b1;
		min_inc   = st.runtime_minutes_count + 1'b1;
		ron       = st.run_on_count;

		if (manual) begin
			st_next.pump_relay = (cfg.operating_mode == sbcc_pkg::MODE_MANUAL_ON);
		end else begin
			st_next.runtime_prescale = (rp_inc >= (sbcc_pkg::PRESC_W+1)'(sbcc_pkg::TICKS_PER_MINUTE))
			                           ? '0 : rp_inc[sbcc_pkg::PRESC_W-1:0];
			if (st_next.runtime_prescale == '0 && cfg.pump_static && st.pump_relay) begin
				if (min_inc >= sbcc_pkg::MIN_W'(sbcc_pkg::MINUTES_PER_HOUR)) begin
					st_next.runtime_minutes_count = '0;
					st_next.runtime_hours_count   = st.runtime_hours_count + 1'b1;
					hours_upd                     = 1'b1;
				end else begin
					st_next.runtime_minutes_count = min_inc;
				end
			end

			if (start_ok) begin
				st_next.charge_flag = 1'b1;
			end else if (stop_ok) begin
				st_next.charge_flag = 1'b0;
			end

			if (st_next.charge_flag) begin
				// a run-on of 255 wraps to zero
				st_next.run_on_count = cfg.run_on_minutes + 1'b1;
				st_next.pump_relay   = 1'b1;
			end else begin
				st_next.off_prescale = (op_inc >= (sbcc_pkg::PRESC_W+1)'(sbcc_pkg::TICKS_PER_MINUTE))
				                       ? '0 : op_inc[sbcc_pkg::PRESC_W-1:0];
				if (st_next.off_prescale == '0) begin
					if (ron != '0) begin
						ron = ron - 1'b1;
					end
					st_next.run_on_count = ron;
					if (ron == '0) begin
						st_next.pump_relay = 1'b0;
					end
				end
			end
		end

		res.pump_on       = st_next.pump_relay;
		res.charging      = st_next.charge_flag;
		res.run_on_left   = st_next.run_on_count;
		res.runtime_hours = st_next.runtime_hours_count;
		res.hours_updated = hours_upd;
	end

endmodule

@@ hdl/solar_buffer_charge_controller.sv @@
// ---------------------------------------------------------------------------
// Solar buffer charge controller
// Buffer charging control with run-on timer and pump runtime counter.
// ---------------------------------------------------------------------------
// One sensor request is taken per clock cycle while results are taken as they
// appear: the request is captured in an input register, the controller state
// advances as it moves into the result register, and the result waits there
// until taken while the next request is already captured. The throughput of
// one request per cycle is set by the single path from the state registers
// through the sensor select and threshold compares back into the state
// registers. Configuration writes are taken in every cycle and are meant to
// happen while no request is in flight.
module solar_buffer_charge_controller (
	input  logic            clk,
	input  logic            arst_n,
	sbcc_cfg_if.sink        cfg,
	sbcc_item_if.sink       item,
	sbcc_result_if.source   result
);

	sbcc_pkg::cfg_t     regs;
	sbcc_pkg::item_t    item_s1;
	logic               valid_s1;
	sbcc_pkg::result_t  res_s2;
	logic               valid_s2;
	sbcc_pkg::state_t   state_q;
	sbcc_pkg::state_t   state_next;
	sbcc_pkg::result_t  res_next;
	logic               accept_in;
	logic               advance;

	sbcc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	sbcc_tick_logic u_tick_logic (
		.cfg     (regs),
		.st      (state_q),
		.it      (item_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept_in  = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			valid_s1 <= accept_in || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && !result.ready);
			if (advance) begin
				state_q <= state_next;
			end
		end
	end

	// payload registers: capture on request and on advance
	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_s1.upper_temp     <= item.upper_temp;
			item_s1.upper_ok       <= item.upper_ok;
			item_s1.lower_temp     <= item.lower_temp;
			item_s1.lower_ok       <= item.lower_ok;
			item_s1.collector_temp <= item.collector_temp;
			item_s1.collector_ok   <= item.collector_ok;
			item_s1.alarm_present  <= item.alarm_present;
			item_s1.alarm_active   <= item.alarm_active;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result.valid         = valid_s2;
	assign result.pump_on       = res_s2.pump_on;
	assign result.charging      = res_s2.charging;
	assign result.run_on_left   = res_s2.run_on_left;
	assign result.runtime_hours = res_s2.runtime_hours;
	assign result.hours_updated = res_s2.hours_updated;

endmodule

@@ hdl/sbcc_checker.sv @@
// ---------------------------------------------------------------------------
// Port checker
// Watches the top level's channels for stalls, back-pressure and results.
// ---------------------------------------------------------------------------
`include "solar_buffer_charge_controller_macros.svh"

module sbcc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          pump_on,
	input logic                          charging,
	input logic [sbcc_pkg::RUNON_W-1:0]  run_on_left,
	input logic [sbcc_pkg::HOURS_W-1:0]  runtime_hours,
	input logic                          hours_updated
);

	// hold a stalled result
	`SBCC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(pump_on) && $stable(charging) && $stable(run_on_left) && $stable(runtime_hours) && $stable(hours_updated))

	// a presented result carries no unknown bits
	`SBCC_ASSERT_IMPL(a_out_known, clk, arst_n, out_valid, !$isunknown({pump_on, charging, run_on_left, runtime_hours, hours_updated}))

	// drop input ready only under output back-pressure
	`SBCC_ASSERT_IMPL(a_ready_backpressure, clk, arst_n, !in_ready, out_valid && !out_ready)

	// a new result follows an accepted request through the input register
	`SBCC_ASSERT_IMPL(a_result_source, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind solar_buffer_charge_controller sbcc_checker u_sbcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (item.valid),
	.in_ready      (item.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.pump_on       (result.pump_on),
	.charging      (result.charging),
	.run_on_left   (result.run_on_left),
	.runtime_hours (result.runtime_hours),
	.hours_updated (result.hours_updated)
);

@@ dv/solar_buffer_charge_controller_test.sv @@
// ---------------------------------------------------------------------------
// Solar buffer charge controller testbench
// Drives sensor requests and register writes into the controller and checks
// each status result against a cycle-free model of the charge logic, the
// run-on timer and the runtime counter. A directed opening exercises sensor
// selection, the start and stop conditions and the manual modes; random
// phases follow a drifting plant under several register settings, with
// random idling on both channels.
// ---------------------------------------------------------------------------
module solar_buffer_charge_controller_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sbcc_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int TEMP_LO      = -999;
	localparam int TEMP_HI      = 3000;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_LIMIT = 40;

	class charge_scoreboard;
		cfg_t    regs;
		state_t  st;
		result_t expected_status[$];
		int      mismatches;

		function new();
			regs = CFG_RESET;
			st = '0;
			mismatches = 0;
		endfunction

		function void note_write(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
			REG_OPERATING_MODE:       regs.operating_mode = d[MODE_W-1:0];
			REG_PUMP_STATIC:          regs.pump_static = d[0];
			REG_COLLECTOR_START_TEMP: regs.collector_start_temp = d[TEMP_W-1:0];
			REG_COLLECTOR_END_TEMP:   regs.collector_end_temp = d[TEMP_W-1:0];
			REG_DIFF_START:           regs.diff_start = d[DIFF_W-1:0];
			REG_DIFF_END:             regs.diff_end = d[DIFF_W-1:0];
			REG_BUFFER_MAX_TEMP:      regs.buffer_max_temp = d[TEMP_W-1:0];
			REG_RUN_ON_MINUTES:       regs.run_on_minutes = d[RUNON_W-1:0];
			default: ;
			endcase
		endfunction

		function void note_request(item_t r);
			int up, lo, coll, tmax, tmin, limit, start_t, end_t, ds, de;
			logic alarm;
			result_t res;
			res = '0;
			if (regs.operating_mode == MODE_MANUAL_OFF || regs.operating_mode == MODE_MANUAL_ON) begin
				// manual: set the relay, hold everything else
				st.pump_relay = (regs.operating_mode == MODE_MANUAL_ON);
			end else begin
				up = int'(r.upper_temp);
				lo = int'(r.lower_temp);
				coll = int'(r.collector_temp);
				alarm = r.alarm_present && r.alarm_active;
				limit = int'(regs.buffer_max_temp);
				start_t = int'(regs.collector_start_temp);
				end_t = int'(regs.collector_end_temp);
				ds = int'(regs.diff_start);
				de = int'(regs.diff_end);

				st.runtime_prescale = (st.runtime_prescale == TICKS_PER_MINUTE - 1) ?
					'0 : st.runtime_prescale + 1'b1;
				if (st.runtime_prescale == 0 && regs.pump_static && st.pump_relay) begin
					if (st.runtime_minutes_count == MINUTES_PER_HOUR - 1) begin
						st.runtime_minutes_count = '0;
						st.runtime_hours_count = st.runtime_hours_count + 1'b1;
						res.hours_updated = 1'b1;
					end else begin
						st.runtime_minutes_count = st.runtime_minutes_count + 1'b1;
					end
				end

				// no healthy buffer sensor: pretend the buffer is just over its limit
				tmax = limit + 1;
				tmin = limit + 1;
				if (r.upper_ok && r.lower_ok) begin
					tmax = (up > lo) ? up : lo;
					tmin = (up > lo) ? lo : up;
				end else if (r.upper_ok) begin
					tmax = up;
					tmin = up;
				end else if (r.lower_ok) begin
					tmax = lo;
					tmin = lo;
				end

				if (!st.charge_flag && r.collector_ok && coll > start_t && coll - tmin > ds
						&& tmax < limit - LIMIT_MARGIN && !alarm) begin
					st.charge_flag = 1'b1;
				end else if (st.charge_flag && (tmax >= limit || coll < end_t
						|| coll - tmin < de || alarm)) begin
					st.charge_flag = 1'b0;
				end

				if (st.charge_flag) begin
					st.run_on_count = regs.run_on_minutes + 8'd1;
					st.pump_relay = 1'b1;
				end else begin
					st.off_prescale = (st.off_prescale == TICKS_PER_MINUTE - 1) ?
						'0 : st.off_prescale + 1'b1;
					if (st.off_prescale == 0) begin
						if (st.run_on_count != 0)
							st.run_on_count = st.run_on_count - 1'b1;
						if (st.run_on_count == 0)
							st.pump_relay = 1'b0;
					end
				end
			end
			res.pump_on = st.pump_relay;
			res.charging = st.charge_flag;
			res.run_on_left = st.run_on_count;
			res.runtime_hours = st.runtime_hours_count;
			expected_status.push_back(res);
		endfunction

		function void report(string field, logic [HOURS_W-1:0] want, logic [HOURS_W-1:0] seen);
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_status.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
				return;
			end
			want = expected_status.pop_front();
			report("pump_on", HOURS_W'(want.pump_on), HOURS_W'(got.pump_on));
			report("charging", HOURS_W'(want.charging), HOURS_W'(got.charging));
			report("run_on_left", HOURS_W'(want.run_on_left), HOURS_W'(got.run_on_left));
			report("runtime_hours", want.runtime_hours, got.runtime_hours);
			report("hours_updated", HOURS_W'(want.hours_updated), HOURS_W'(got.hours_updated));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sbcc_cfg_if    cfg_ch();
	sbcc_item_if   item_ch();
	sbcc_result_if result_ch();

	solar_buffer_charge_controller u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	charge_scoreboard book = new();
	int          send_idle;
	int          take_idle;
	int          coll_level;
	int          buf_level;
	int unsigned cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int clamp_temp(int v);
		return (v < TEMP_LO) ? TEMP_LO : (v > TEMP_HI) ? TEMP_HI : v;
	endfunction

	function automatic int rand_temp();
		return int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic item_t make_item(int up, bit uok, int lo, bit lok, int co, bit cok,
			bit ap, bit aa);
		item_t r;
		r.upper_temp = up[TEMP_W-1:0];
		r.upper_ok = uok;
		r.lower_temp = lo[TEMP_W-1:0];
		r.lower_ok = lok;
		r.collector_temp = co[TEMP_W-1:0];
		r.collector_ok = cok;
		r.alarm_present = ap;
		r.alarm_active = aa;
		return r;
	endfunction

	// drift the collector and the buffer slowly, with the odd jump and noise request
	function automatic item_t plant_item();
		int spread;
		if ($urandom_range(19) == 0)
			return make_item(rand_temp(), 1'($urandom_range(1)), rand_temp(),
				1'($urandom_range(1)), rand_temp(), 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'($urandom_range(1)));
		coll_level = ($urandom_range(49) == 0) ? rand_temp() :
			clamp_temp(coll_level + int'($urandom_range(60)) - 30);
		buf_level = ($urandom_range(49) == 0) ? rand_temp() :
			clamp_temp(buf_level + int'($urandom_range(10)) - 4);
		spread = int'($urandom_range(30));
		return make_item(clamp_temp(buf_level + spread), $urandom_range(31) != 0,
			clamp_temp(buf_level - int'($urandom_range(30))), $urandom_range(31) != 0,
			coll_level, $urandom_range(31) != 0, 1'($urandom_range(1)), $urandom_range(24) == 0);
	endfunction

	function automatic cfg_t rand_settings(logic [MODE_W-1:0] mode);
		cfg_t s;
		int start_t;
		start_t = rand_temp();
		s.operating_mode = mode;
		s.pump_static = 1'($urandom_range(1));
		s.collector_start_temp = start_t[TEMP_W-1:0];
		s.collector_end_temp = TEMP_W'(clamp_temp(start_t - int'($urandom_range(400))));
		s.diff_start = ($urandom_range(9) == 0) ? DIFF_W'($urandom_range(1000)) :
			DIFF_W'($urandom_range(150));
		s.diff_end = DIFF_W'($urandom_range(s.diff_start));
		s.buffer_max_temp = TEMP_W'($urandom_range(300, TEMP_HI));
		s.run_on_minutes = RUNON_W'($urandom_range(12));
		return s;
	endfunction

	task automatic send_request(item_t r);
		int unsigned gap;
		gap = pick_gap(send_idle);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.upper_temp <= r.upper_temp;
		item_ch.upper_ok <= r.upper_ok;
		item_ch.lower_temp <= r.lower_temp;
		item_ch.lower_ok <= r.lower_ok;
		item_ch.collector_temp <= r.collector_temp;
		item_ch.collector_ok <= r.collector_ok;
		item_ch.alarm_present <= r.alarm_present;
		item_ch.alarm_active <= r.alarm_active;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		book.note_request(r);
	endtask

	task automatic apply_settings(cfg_t s);
		logic [CFG_DATA_W-1:0] vals [8];
		vals[REG_OPERATING_MODE] = CFG_DATA_W'(s.operating_mode);
		vals[REG_PUMP_STATIC] = CFG_DATA_W'(s.pump_static);
		vals[REG_COLLECTOR_START_TEMP] = s.collector_start_temp;
		vals[REG_COLLECTOR_END_TEMP] = s.collector_end_temp;
		vals[REG_DIFF_START] = CFG_DATA_W'(s.diff_start);
		vals[REG_DIFF_END] = CFG_DATA_W'(s.diff_end);
		vals[REG_BUFFER_MAX_TEMP] = s.buffer_max_temp;
		vals[REG_RUN_ON_MINUTES] = CFG_DATA_W'(s.run_on_minutes);
		for (int i = 0; i < 8; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.reg_index <= IDX_W'(i);
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (cfg_ch.ready !== 1'b1);
			book.note_write(IDX_W'(i), vals[i]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	// hold requests until every result is back, then let the pipeline settle
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (book.expected_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : take_results
		int unsigned stall_left;
		int unsigned gap;
		result_t got;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.pump_on = result_ch.pump_on;
				got.charging = result_ch.charging;
				got.run_on_left = result_ch.run_on_left;
				got.runtime_hours = result_ch.runtime_hours;
				got.hours_updated = result_ch.hours_updated;
				book.check_result(got);
			end
			if (stall_left != 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				gap = pick_gap(take_idle);
				result_ch.ready <= (gap == 0);
				stall_left = (gap == 0) ? 0 : gap - 1;
			end
		end
	end

	initial begin : run_stimulus
		cfg_t s;
		int n;
		item_t charge_ok;
		logic [MODE_W-1:0] manual_modes [3];

		send_idle = 15;
		take_idle = 15;
		item_ch.valid <= 1'b0;
		item_ch.upper_temp <= '0;
		item_ch.upper_ok <= 1'b0;
		item_ch.lower_temp <= '0;
		item_ch.lower_ok <= 1'b0;
		item_ch.collector_temp <= '0;
		item_ch.collector_ok <= 1'b0;
		item_ch.alarm_present <= 1'b0;
		item_ch.alarm_active <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.reg_index <= '0;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed opening under the reset settings
		charge_ok = make_item(500, 1, 400, 1, 700, 1, 0, 0);
		send_request(make_item(TEMP_LO, 1, TEMP_LO, 1, TEMP_LO, 1, 0, 0));
		send_request(make_item(TEMP_HI, 1, TEMP_HI, 1, TEMP_HI, 1, 1, 1));
		send_request(charge_ok);
		send_request(make_item(500, 1, 400, 1, 700, 1, 1, 0));
		send_request(make_item(500, 1, 400, 1, 700, 1, 0, 1));
		send_request(make_item(500, 1, 400, 1, 700, 1, 1, 1));
		send_request(charge_ok);
		// stop on buffer limit, collector end temperature, end difference
		send_request(make_item(900, 1, 400, 1, 700, 1, 0, 0));
		send_request(charge_ok);
		send_request(make_item(500, 1, 200, 1, 299, 1, 0, 0));
		send_request(charge_ok);
		send_request(make_item(500, 1, 400, 1, 420, 1, 0, 0));
		send_request(charge_ok);

		// manual modes hold the charge state; the unused mode runs as automatic
		manual_modes[0] = MODE_MANUAL_ON;
		manual_modes[1] = MODE_MANUAL_OFF;
		manual_modes[2] = MODE_UNUSED;
		foreach (manual_modes[i]) begin
			drain();
			s = CFG_RESET;
			s.operating_mode = manual_modes[i];
			apply_settings(s);
			send_request(charge_ok);
			send_request(make_item(TEMP_HI, 1, TEMP_HI, 1, TEMP_LO, 0, 1, 1));
		end
		send_request(charge_ok);
		// a faulty collector sensor does not stop charging
		send_request(make_item(500, 1, 400, 1, 700, 0, 0, 0));
		send_request(make_item(TEMP_LO, 0, 400, 1, 700, 1, 0, 0));
		send_request(make_item(500, 1, TEMP_LO, 0, 700, 1, 0, 0));
		send_request(make_item(500, 0, 400, 0, 700, 1, 0, 0));
		send_request(make_item(500, 0, 400, 0, TEMP_HI, 1, 0, 0));
		send_request(make_item(500, 1, 400, 1, 700, 0, 0, 0));

		for (int k = 0; k < 11; k++) begin
			s = rand_settings(MODE_AUTO);
			n = 120;
			case (k)
			0: begin
				s = CFG_RESET;
				n = 400;
			end
			1: begin
				s.pump_static = 1'b1;
				s.collector_start_temp = TEMP_W'(TEMP_LO);
				s.collector_end_temp = TEMP_W'(TEMP_LO);
				s.diff_start = '0;
				s.diff_end = '0;
				s.buffer_max_temp = TEMP_W'(TEMP_HI);
				s.run_on_minutes = 8'd254;
				n = 450;
			end
			2: begin
				s.pump_static = 1'b0;
				s.collector_start_temp = TEMP_W'(TEMP_HI);
				s.collector_end_temp = TEMP_W'(TEMP_HI);
				s.diff_start = 10'd1000;
				s.diff_end = 10'd1000;
				s.buffer_max_temp = TEMP_W'(TEMP_LO);
				s.run_on_minutes = '0;
				n = 100;
			end
			3: begin
				// run-on load wraps to zero
				s.pump_static = 1'b1;
				s.collector_start_temp = 13'sd200;
				s.collector_end_temp = 13'sd100;
				s.diff_start = 10'd20;
				s.diff_end = 10'd10;
				s.buffer_max_temp = TEMP_W'(TEMP_HI);
				s.run_on_minutes = 8'd255;
				n = 200;
			end
			4: begin
				s = rand_settings(MODE_MANUAL_ON);
				n = 60;
			end
			5: begin
				s = rand_settings(MODE_MANUAL_OFF);
				n = 60;
			end
			6: begin
				s = rand_settings(MODE_UNUSED);
				n = 100;
			end
			default: ;
			endcase
			drain();
			apply_settings(s);
			coll_level = clamp_temp(int'(s.collector_start_temp) + int'($urandom_range(600)) - 300);
			buf_level = clamp_temp(int'(s.buffer_max_temp) - int'($urandom_range(50, 800)));
			send_idle = 20 * int'($urandom_range(2));
			take_idle = 20 * int'($urandom_range(2));
			repeat (n) send_request(plant_item());
		end

		drain();
		if (book.mismatches == 0 && book.expected_status.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
